// ===== sv/pir_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, coefficient table and queue entry type of the resampler.
package pir_pkg;

  localparam int ORDER        = 4;
  localparam int NPTS         = ORDER + 1;
  localparam int SAMPLE_WIDTH = 16;
  localparam int STEP_WIDTH   = 21;
  localparam int COUNT_WIDTH  = 32;
  localparam int FRAC_WIDTH   = 16;
  localparam int INT_WIDTH    = 33;
  localparam int TIME_WIDTH   = INT_WIDTH + FRAC_WIDTH;
  localparam int COEF_WIDTH   = 24;
  localparam int ACC_WIDTH    = 48;
  localparam int KIDX_WIDTH   = 3;
  localparam int CNT_WIDTH    = 5;
  localparam int MAX_OUT      = 16;
  localparam int HI_OFF       = (NPTS + 1) / 2 - 1;
  localparam int MID_OFF      = NPTS / 2;

  localparam logic [STEP_WIDTH-1:0] STEP_MIN   = STEP_WIDTH'(4096);
  localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(32768);
  localparam logic [TIME_WIDTH-1:0] TIME_START = TIME_WIDTH'((ORDER + 2) << 15);

  // Final scaling divides by 24 * 2^16: an arithmetic shift by 19, then by 3.
  localparam int SCALE_SHIFT = 19;
  localparam int Q_WIDTH     = ACC_WIDTH - SCALE_SHIFT;
  localparam int U_WIDTH     = 18;
  localparam int RECIP_WIDTH = 19;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD3_WIDTH = U_WIDTH + RECIP_WIDTH;
  localparam logic signed [ACC_WIDTH-1:0] ROUND_OFFSET = ACC_WIDTH'(24 * 32768);
  localparam logic signed [Q_WIDTH-1:0]   SAT_SPAN     = Q_WIDTH'(98304);
  localparam logic [RECIP_WIDTH-1:0]      RECIP_3      = RECIP_WIDTH'(349526);

  typedef logic signed [6:0] basis_t;

  // ORDER! times the Lagrange basis polynomials for nodes -2..2, row = node,
  // column = power of x.
  localparam basis_t BASIS [NPTS][NPTS] = '{
    '{ 7'sd0,   7'sd2,  -7'sd1,  -7'sd2,  7'sd1},
    '{ 7'sd0,  -7'sd16,  7'sd16,  7'sd4, -7'sd4},
    '{ 7'sd24,  7'sd0,  -7'sd30,  7'sd0,  7'sd6},
    '{ 7'sd0,   7'sd16,  7'sd16, -7'sd4, -7'sd4},
    '{ 7'sd0,  -7'sd2,  -7'sd1,   7'sd2,  7'sd1}
  };

  typedef struct packed {
    logic [NPTS-1:0][SAMPLE_WIDTH-1:0] window;
    logic [COUNT_WIDTH-1:0]            count;
    logic                              fin;
  } pir_entry_t;

endpackage

// ===== sv/pir_sample_if.sv =====
`timescale 1ns / 1ps
// Input channel carrying one series sample per transaction.
interface pir_sample_if;
  logic                                valid;
  logic                                ready;
  logic [pir_pkg::SAMPLE_WIDTH-1:0]    sample;
  logic                                final_sample;

  modport source (output valid, sample, final_sample, input ready);
  modport sink (input valid, sample, final_sample, output ready);
endinterface

// ===== sv/pir_result_if.sv =====
`timescale 1ns / 1ps
// Output channel carrying one interpolated value per transaction.
interface pir_result_if;
  logic                                valid;
  logic                                ready;
  logic [pir_pkg::SAMPLE_WIDTH-1:0]    value;
  logic                                end_of_run;

  modport source (output valid, value, end_of_run, input ready);
  modport sink (input valid, value, end_of_run, output ready);
endinterface

// ===== sv/polynomial_interpolation_resampler.sv =====
`timescale 1ns / 1ps
// Polynomial interpolation resampler, fourth order, 16-bit signed samples.
//
// Samples arrive on the samples channel (valid/ready), results leave on the
// results channel. The user must write the step register (Q5.16, below 4096
// used as 4096) through cfg_we/cfg_wdata only while the block is idle; the
// block itself does not enforce this. The step register resets to 0.5. Each
// sample may cause zero to sixteen results; end_of_run marks the last result
// caused by a sample. The sample after which final_sample is set ends the
// series: later samples are taken and dropped until reset. A front end shifts
// the sample window and queues it in a two-entry queue, so samples keep flowing
// while the back end works. The back end builds the five polynomial
// coefficients at most once per sample, then evaluates each result by Horner's
// rule: a check, alternating multiply and add steps, a rounding step, a scaling
// step and an output step. A stalled receiver holds the output register, the
// back end waits in its output step, and the queue fills before samples.ready
// drops. Reset clears the window, count and all valid flags and sets the
// output time to its start value.
module polynomial_interpolation_resampler (
  input  logic                           clk,
  input  logic                           rst,
  pir_sample_if.sink                     samples,
  pir_result_if.source                   results,
  input  logic                           cfg_we,
  input  logic [pir_pkg::STEP_WIDTH-1:0] cfg_wdata
);
  import pir_pkg::*;

  logic [STEP_WIDTH-1:0] step;
  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  empty;
  pir_entry_t            push_data;
  pir_entry_t            pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_RESET;
    end else if (cfg_we) begin
      step <= cfg_wdata;
    end
  end

  pir_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  pir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  pir_back u_back (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .results  (results)
  );
endmodule

// ===== sv/pir_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between the sample front end and the evaluation back end.
module pir_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pir_pkg::pir_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output pir_pkg::pir_entry_t pop_data,
  output logic                empty
);
  import pir_pkg::*;

  pir_entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end
endmodule

// ===== sv/pir_front.sv =====
`timescale 1ns / 1ps
// Front end: takes samples, keeps the window and sample count, queues work.
module pir_front (
  input  logic                clk,
  input  logic                rst,
  pir_sample_if.sink          samples,
  output logic                push,
  output pir_pkg::pir_entry_t push_data,
  input  logic                full
);
  import pir_pkg::*;

  logic [NPTS-1:0][SAMPLE_WIDTH-1:0] window;
  logic [NPTS-1:0][SAMPLE_WIDTH-1:0] window_next;
  logic [COUNT_WIDTH-1:0]            samples_seen;
  logic                              stream_done;
  logic                              accept;

  // Once the stream has ended, samples are still taken but dropped.
  assign samples.ready = stream_done || !full;
  assign accept        = samples.valid && samples.ready;
  assign push          = accept && !stream_done;

  always_comb begin
    window_next           = window >> SAMPLE_WIDTH;
    window_next[NPTS-1]   = samples.sample;
    push_data.window      = window_next;
    push_data.count       = samples_seen;
    push_data.fin         = samples.final_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      samples_seen <= '0;
      stream_done  <= 1'b0;
    end else if (push) begin
      window <= window_next;
      if (samples_seen != '1) begin
        samples_seen <= samples_seen + COUNT_WIDTH'(1);
      end
      if (samples.final_sample) begin
        stream_done <= 1'b1;
      end
    end
  end
endmodule

// ===== sv/pir_back.sv =====
`timescale 1ns / 1ps
// Back end: builds the polynomial and evaluates it by Horner's rule.
module pir_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pir_pkg::STEP_WIDTH-1:0] step,
  input  pir_pkg::pir_entry_t            pop_data,
  input  logic                           empty,
  output logic                           pop,
  pir_result_if.source                   results
);
  import pir_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_COEF, S_MUL, S_ADD, S_ROUND, S_SCALE, S_EMIT
  } state_t;

  state_t                            state;
  logic [NPTS-1:0][SAMPLE_WIDTH-1:0] win;
  logic [COUNT_WIDTH-1:0]            n_cur;
  logic                              fin_cur;
  logic [CNT_WIDTH-1:0]              cnt;
  logic                              have_coef;
  logic [KIDX_WIDTH-1:0]             kidx;
  logic signed [COEF_WIDTH-1:0]      coef [NPTS];
  logic signed [ACC_WIDTH-1:0]       acc;
  logic signed [ACC_WIDTH:0]         prod_hi;
  logic [FRAC_WIDTH-1:0]             prod_lo;
  logic                              sat_hi;
  logic                              sat_lo;
  logic [U_WIDTH-1:0]                u_val;
  logic [PROD3_WIDTH-1:0]            scaled;
  logic [TIME_WIDTH-1:0]             output_time;

  logic [STEP_WIDTH-1:0]             st;
  logic [TIME_WIDTH-1:0]             time_adv;
  logic signed [COEF_WIDTH-1:0]      csum;
  logic signed [ACC_WIDTH-1:0]       coef_shift;
  logic signed [ACC_WIDTH-1:0]       rounded;
  logic signed [Q_WIDTH-1:0]         q;
  logic                              emit_now;
  logic                              emit_after;
  logic                              out_free;
  logic [FRAC_WIDTH-1:0]             frac;
  logic [2*FRAC_WIDTH-1:0]           lo_prod;

  function automatic logic may_emit(input logic [TIME_WIDTH-1:0] t,
                                    input logic [COUNT_WIDTH-1:0] n,
                                    input logic fin,
                                    input logic [CNT_WIDTH-1:0] c);
    logic [INT_WIDTH:0] ip;
    logic [INT_WIDTH:0] nn;
    ip = {1'b0, t[TIME_WIDTH-1:FRAC_WIDTH]};
    nn = (INT_WIDTH + 1)'(n);
    return (c < CNT_WIDTH'(MAX_OUT)) && (ip + (INT_WIDTH + 1)'(HI_OFF) <= nn) &&
           !(fin && (ip + (INT_WIDTH + 1)'(MID_OFF) >= nn + (INT_WIDTH + 1)'(1)));
  endfunction

  assign st         = (step < STEP_MIN) ? STEP_MIN : step;
  assign time_adv   = output_time + TIME_WIDTH'(st);
  assign emit_now   = may_emit(output_time, n_cur, fin_cur, cnt);
  assign emit_after = may_emit(time_adv, n_cur, fin_cur, cnt + CNT_WIDTH'(1));
  assign out_free   = !results.valid || results.ready;
  assign pop        = (state == S_IDLE) && !empty;
  assign frac       = output_time[FRAC_WIDTH-1:0];
  assign lo_prod    = (2 * FRAC_WIDTH)'(acc[FRAC_WIDTH-1:0]) * (2 * FRAC_WIDTH)'(frac);
  assign coef_shift = ACC_WIDTH'(coef[kidx]) <<< FRAC_WIDTH;
  assign rounded    = acc + ROUND_OFFSET;
  assign q          = Q_WIDTH'(rounded >>> SCALE_SHIFT);

  always_comb begin
    csum = '0;
    for (int i = 0; i < NPTS; i++) begin
      csum = csum + COEF_WIDTH'($signed(win[i])) * COEF_WIDTH'(BASIS[i][kidx]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      output_time        <= TIME_START;
      results.valid      <= 1'b0;
      cnt                <= '0;
      have_coef          <= 1'b0;
      kidx               <= '0;
    end else begin
      // In the output state the valid flag is handled by the state itself.
      if (results.valid && results.ready && (state != S_EMIT)) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            win       <= pop_data.window;
            n_cur     <= pop_data.count;
            fin_cur   <= pop_data.fin;
            cnt       <= '0;
            have_coef <= 1'b0;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!emit_now) begin
            state <= S_IDLE;
          end else if (!have_coef) begin
            kidx  <= '0;
            state <= S_COEF;
          end else begin
            acc   <= ACC_WIDTH'(coef[NPTS-1]) <<< FRAC_WIDTH;
            kidx  <= KIDX_WIDTH'(NPTS - 2);
            state <= S_MUL;
          end
        end
        S_COEF: begin
          coef[kidx] <= csum;
          if (kidx == KIDX_WIDTH'(NPTS - 1)) begin
            have_coef <= 1'b1;
            acc       <= ACC_WIDTH'(csum) <<< FRAC_WIDTH;
            kidx      <= KIDX_WIDTH'(NPTS - 2);
            state     <= S_MUL;
          end else begin
            kidx <= kidx + KIDX_WIDTH'(1);
          end
        end
        S_MUL: begin
          prod_hi <= (ACC_WIDTH + 1)'($signed(acc[ACC_WIDTH-1:FRAC_WIDTH])) *
                     (ACC_WIDTH + 1)'($signed({1'b0, frac}));
          prod_lo <= FRAC_WIDTH'((lo_prod + (2 * FRAC_WIDTH)'(32768)) >> FRAC_WIDTH);
          state   <= S_ADD;
        end
        S_ADD: begin
          acc <= ACC_WIDTH'(prod_hi) + ACC_WIDTH'(prod_lo) + coef_shift;
          if (kidx == '0) begin
            state <= S_ROUND;
          end else begin
            kidx  <= kidx - KIDX_WIDTH'(1);
            state <= S_MUL;
          end
        end
        S_ROUND: begin
          sat_hi <= (q >= SAT_SPAN);
          sat_lo <= (q < -SAT_SPAN);
          u_val  <= U_WIDTH'(q + SAT_SPAN);
          state  <= S_SCALE;
        end
        S_SCALE: begin
          scaled <= PROD3_WIDTH'(u_val) * PROD3_WIDTH'(RECIP_3);
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            results.valid      <= 1'b1;
            results.end_of_run <= !emit_after;
            if (sat_hi) begin
              results.value <= {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
            end else if (sat_lo) begin
              results.value <= {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
            end else begin
              // The quotient is offset by half the range; flipping the sign bit removes it.
              results.value <= {~scaled[RECIP_SHIFT + SAMPLE_WIDTH - 1],
                                scaled[RECIP_SHIFT + SAMPLE_WIDTH - 2:RECIP_SHIFT]};
            end
            output_time <= time_adv;
            cnt         <= cnt + CNT_WIDTH'(1);
            state       <= S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
